// File: hdl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// shared types and constants for the modbus tcp transaction parser
// ----------------------------------------------------------------------------
package mtp_pkg;

    localparam int unsigned POS_W = 16;

    typedef enum logic [1:0] {
        KIND_REG     = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_IGNORED = 2'd2
    } kind_t;

    localparam logic [7:0] FC_EXC_BIT = 8'h80;
    localparam logic [7:0] FC_MASK    = 8'h7F;

    // one classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] pos;
        logic        last;
        logic        start;
        logic [15:0] flow;
    } byte_op_t;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [15:0] flow;
        logic [15:0] tid;
        logic        is_resp;
        logic [6:0]  fc;
        logic        is_exc;
        logic [5:0]  mask;
        logic [7:0]  err;
        logic [7:0]  bc;
        logic [16:0] addr;
        logic [15:0] val;
        logic        last;
    } result_t;

endpackage

// File: hdl/mtp_front.sv
// ----------------------------------------------------------------------------
// mtp_front
// accepts payload bytes, tracks the byte position and queues byte operations
// ----------------------------------------------------------------------------
module mtp_front #(
    parameter int FLOW_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_payload_byte,
    input  logic              s_first_byte,
    input  logic              s_last_byte,
    input  logic [15:0]       s_flow_tag,
    output logic              op_valid,
    input  logic              op_ready,
    output mtp_pkg::byte_op_t op
);
    import mtp_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic        after_last_reg, after_last_next;
    byte_op_t    q_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_ptr_reg, wr_ptr_reg;
    logic        push, pop;
    byte_op_t    op_in;
    logic [15:0] cur_pos;
    logic [15:0] fmask;

    assign fmask = 16'((32'd1 << FLOW_BITS) - 32'd1);
    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign op_valid = (cnt_reg != 2'd0);
    assign pop = op_valid && op_ready;
    assign op = q_reg[rd_ptr_reg];

    always_comb begin
        cur_pos = (s_first_byte || after_last_reg) ? 16'd0 : pos_reg;
        op_in.data  = s_payload_byte;
        op_in.pos   = cur_pos;
        op_in.last  = s_last_byte;
        op_in.start = (cur_pos == 16'd0);
        op_in.flow  = s_flow_tag & fmask;
        pos_next = pos_reg;
        after_last_next = after_last_reg;
        if (push) begin
            after_last_next = 1'b0;
            if (s_last_byte) begin
                pos_next = 16'd0;
            end else if (cur_pos != 16'hFFFF) begin
                pos_next = cur_pos + 16'd1;
            end else begin
                pos_next = cur_pos;
            end
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            after_last_reg <= 1'b0;
            cnt_reg <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            after_last_reg <= after_last_next;
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= op_in;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && s_last_byte |=> pos_reg == 16'd0)
        else $error("position not cleared after last byte");
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count");

endmodule

// File: hdl/mtp_back.sv
// ----------------------------------------------------------------------------
// mtp_back
// per-packet decode, pending table match and result generation
// ----------------------------------------------------------------------------
module mtp_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              op_valid,
    output logic              op_ready,
    input  mtp_pkg::byte_op_t op,
    output logic              r_valid,
    input  logic              r_ready,
    output mtp_pkg::result_t  r_data
);
    import mtp_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic               tv_reg [TABLE_ENTRIES];
    logic [15:0]        tflow_reg [TABLE_ENTRIES];
    logic [15:0]        ttid_reg [TABLE_ENTRIES];
    logic [15:0]        tstart_reg [TABLE_ENTRIES];

    logic [15:0] flow_reg, tid_reg;
    logic        hdr_reg, hit_reg;
    logic [IW-1:0] hidx_reg;
    logic [7:0]  fn_reg, hi_reg;
    logic [7:0]  pdu_reg [5];

    result_t     q_reg [2];
    logic [1:0]  cnt_reg;
    logic        rd_reg;

    logic        take;
    logic [15:0] flow_c, tid_c;
    logic        hdr_c, hit_c;
    logic [IW-1:0] hidx_c;
    logic [7:0]  fn_c, hi_c;
    logic [7:0]  pdu_c [5];
    logic        emit_reg_c, emit_sum_c;
    result_t     reg_r, sum_r;
    logic        free_found;
    logic [IW-1:0] free_idx;
    logic        m_found;
    logic [IW-1:0] m_idx;
    logic [16:0] dl;
    logic [15:0] w0, w1;
    logic        is14, wr_tab, clr_tab;
    logic [15:0] st_c;
    logic [15:0] idx_c;
    logic [1:0]  nres;

    assign r_valid = (cnt_reg != 2'd0);
    assign r_data = q_reg[rd_reg];
    assign op_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && r_ready);
    assign take = op_valid && op_ready;

    always_comb begin
        m_found = 1'b0;
        m_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (tv_reg[i] && tflow_reg[i] == flow_c && ttid_reg[i] == tid_c) begin
                m_found = 1'b1;
                m_idx = IW'(i);
            end
        end
        free_found = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!tv_reg[i]) begin
                free_found = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        if (op.start) begin
            flow_c = op.flow; tid_c = '0; hdr_c = 1'b0; hit_c = 1'b0; hidx_c = '0;
            fn_c = '0; hi_c = '0;
            for (int k = 0; k < 5; k++) pdu_c[k] = '0;
        end else begin
            flow_c = flow_reg; tid_c = tid_reg; hdr_c = hdr_reg; hit_c = hit_reg;
            hidx_c = hidx_reg; fn_c = fn_reg; hi_c = hi_reg;
            for (int k = 0; k < 5; k++) pdu_c[k] = pdu_reg[k];
        end
        if (op.pos == 16'd0) tid_c = {op.data, 8'h00};
        if (op.pos == 16'd1) tid_c = {tid_c[15:8], op.data};
        if (op.pos == 16'd2) hdr_c = (op.data == 8'h00);
        if (op.pos == 16'd3) hdr_c = hdr_c && (op.data == 8'h00);
        if (op.pos == 16'd7) fn_c = op.data;
        if (op.pos >= 16'd9 && op.pos != 16'hFFFF && op.pos[0]) hi_c = op.data;
        for (int k = 0; k < 5; k++)
            if (op.pos == 16'(k + 8)) pdu_c[k] = op.data;
    end

    always_comb begin
        idx_c = (op.pos - 16'd10) >> 1;
        emit_reg_c = 1'b0;
        if (op.pos >= 16'd9 && op.pos != 16'hFFFF && !op.pos[0]) begin
            emit_reg_c = hit_reg && hdr_reg && fn_reg >= 8'd1 && fn_reg <= 8'd4
                && pdu_reg[0] != 8'd0 && idx_c < {9'd0, pdu_reg[0][7:1]};
        end
        reg_r = '0;
        reg_r.kind = KIND_REG;
        reg_r.flow = flow_c;
        reg_r.tid = tid_c;
        reg_r.is_resp = 1'b1;
        reg_r.fc = 7'(fn_reg & FC_MASK);
        reg_r.addr = {1'b0, tstart_reg[hidx_reg]} + {1'b0, idx_c};
        reg_r.val = {hi_reg, op.data};

        emit_sum_c = op.last;
        dl = {1'b0, op.pos} + 17'd1 - 17'd8;
        w0 = {pdu_c[0], pdu_c[1]};
        w1 = {pdu_c[2], pdu_c[3]};
        is14 = fn_c >= 8'd1 && fn_c <= 8'd4;
        sum_r = '0;
        sum_r.flow = flow_c;
        sum_r.tid = tid_c;
        sum_r.last = 1'b1;
        wr_tab = 1'b0;
        clr_tab = 1'b0;
        st_c = '0;
        if (op.pos < 16'd7 || !hdr_c) begin
            sum_r.kind = KIND_IGNORED;
        end else begin
            sum_r.kind = KIND_SUMMARY;
            sum_r.is_resp = hit_c;
            sum_r.fc = 7'(fn_c & FC_MASK);
            sum_r.is_exc = fn_c > FC_EXC_BIT;
            if (fn_c > FC_EXC_BIT) begin
                if (dl >= 17'd1) begin sum_r.mask[0] = 1'b1; sum_r.err = pdu_c[0]; end
            end else if (is14) begin
                if (hit_c) begin
                    if (dl >= 17'd1) begin sum_r.mask[1] = 1'b1; sum_r.bc = pdu_c[0]; end
                end else if (dl >= 17'd4) begin
                    sum_r.mask[3:2] = 2'b11; sum_r.addr = {1'b0, w0}; sum_r.val = w1;
                end
            end else if (fn_c == 8'd5 || fn_c == 8'd6) begin
                if (dl >= 17'd4) begin
                    sum_r.mask[4] = 1'b1; sum_r.mask[2] = 1'b1;
                    sum_r.addr = {1'b0, w0}; sum_r.val = w1;
                end
            end else if (fn_c == 8'd15 || fn_c == 8'd16) begin
                if (hit_c) begin
                    if (dl >= 17'd4) begin
                        sum_r.mask[3:2] = 2'b11; sum_r.addr = {1'b0, w0}; sum_r.val = w1;
                    end
                end else if (dl >= 17'd5) begin
                    sum_r.mask[3:1] = 3'b111; sum_r.addr = {1'b0, w0};
                    sum_r.val = w1; sum_r.bc = pdu_c[4];
                end
            end
            if (hit_c) begin
                clr_tab = 1'b1;
            end else begin
                if ((fn_c >= 8'd1 && fn_c <= 8'd6 || fn_c == 8'd15 || fn_c == 8'd16)
                    && dl >= 17'd3) st_c = w0;
                wr_tab = free_found;
                sum_r.mask[5] = !free_found;
            end
        end
        nres = {1'b0, emit_reg_c} + {1'b0, emit_sum_c};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tv_reg[i] <= 1'b0;
            flow_reg <= '0; tid_reg <= '0; hdr_reg <= 1'b0; hit_reg <= 1'b0;
            hidx_reg <= '0; fn_reg <= '0; hi_reg <= '0;
            for (int k = 0; k < 5; k++) pdu_reg[k] <= '0;
            cnt_reg <= '0;
            rd_reg <= 1'b0;
        end else begin
            if (take) begin
                flow_reg <= flow_c; tid_reg <= tid_c; hdr_reg <= hdr_c;
                hi_reg <= hi_c; fn_reg <= fn_c;
                for (int k = 0; k < 5; k++) pdu_reg[k] <= pdu_c[k];
                if (op.pos == 16'd1) begin
                    hit_reg <= m_found; hidx_reg <= m_idx;
                end else begin
                    hit_reg <= hit_c; hidx_reg <= hidx_c;
                end
                if (op.last && clr_tab) tv_reg[hidx_c] <= 1'b0;
                if (op.last && wr_tab) tv_reg[free_idx] <= 1'b1;
            end
            if (r_valid && r_ready) begin
                rd_reg <= ~rd_reg;
                cnt_reg <= cnt_reg - 2'd1 + (take ? nres : 2'd0);
            end else if (take) begin
                cnt_reg <= cnt_reg + nres;
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic nxt;
        nxt = rd_reg ^ (r_valid && r_ready);
        if (take && op.last && wr_tab) begin
            tflow_reg[free_idx] <= flow_c;
            ttid_reg[free_idx] <= tid_c;
            tstart_reg[free_idx] <= st_c;
        end
        if (take) begin
            if (emit_reg_c && emit_sum_c) begin
                q_reg[nxt] <= reg_r;
                q_reg[~nxt] <= sum_r;
            end else if (emit_reg_c) begin
                q_reg[nxt ^ (cnt_reg == 2'd1 && !r_ready)] <= reg_r;
            end else if (emit_sum_c) begin
                q_reg[nxt ^ (cnt_reg == 2'd1 && !r_ready)] <= sum_r;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("result queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && op.last |=> cnt_reg != 2'd0)
        else $error("summary lost");
    assert property (@(posedge aclk) disable iff (!aresetn)
        r_valid && r_data.kind == KIND_REG |-> !r_data.last)
        else $error("register item marked last");

endmodule

// File: hdl/modbus_tcp_transaction_parser.sv
// ----------------------------------------------------------------------------
// modbus_tcp_transaction_parser
// modbus tcp payload parser with request/response matching
// ----------------------------------------------------------------------------
// Usage: payload bytes enter on the s_ channel one per item, first_byte and
// last_byte framing a packet, flow_tag sampled on the first byte. Results
// leave on the m_ channel: one summary or ignored item per packet at its
// last byte, and one register item per register of a read response.
// Path: an accepted byte passes the front queue, then the result queue,
// before its results appear. Throughput: one byte per cycle while m_ready
// is high, set by the parallel compare over the pending table at payload
// byte 1; a byte that yields two results holds the input until there is room.
// Reset clears the pending table valid bits, the position counter and both
// queues. When m_ready is low the result queue fills, then the front queue,
// then s_ready drops; no item is lost.
// ----------------------------------------------------------------------------
module modbus_tcp_transaction_parser #(
    parameter int TABLE_ENTRIES = 16,
    parameter int FLOW_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    input  logic [15:0] s_flow_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_flow_out,
    output logic [15:0] m_transaction_id,
    output logic        m_is_response,
    output logic [6:0]  m_function_code,
    output logic        m_is_exception,
    output logic [5:0]  m_present_mask,
    output logic [7:0]  m_exception_code,
    output logic [7:0]  m_byte_count_out,
    output logic [16:0] m_address_out,
    output logic [15:0] m_value_out,
    output logic        m_last_result
);
    import mtp_pkg::*;

    logic     op_valid, op_ready;
    byte_op_t op;
    result_t  res;

    mtp_front #(.FLOW_BITS(FLOW_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_payload_byte, .s_first_byte,
        .s_last_byte, .s_flow_tag, .op_valid, .op_ready, .op
    );

    mtp_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .aclk, .aresetn, .op_valid, .op_ready, .op,
        .r_valid(m_valid), .r_ready(m_ready), .r_data(res)
    );

    assign m_kind = res.kind;
    assign m_flow_out = res.flow;
    assign m_transaction_id = res.tid;
    assign m_is_response = res.is_resp;
    assign m_function_code = res.fc;
    assign m_is_exception = res.is_exc;
    assign m_present_mask = res.mask;
    assign m_exception_code = res.err;
    assign m_byte_count_out = res.bc;
    assign m_address_out = res.addr;
    assign m_value_out = res.val;
    assign m_last_result = res.last;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// modbus tcp transaction parser testbench
// drives framed payload bytes with random bursts and gaps, stalls the result
// side, and checks every result item against a predictor of the parser
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mtp_pkg::*;

    localparam int NENT = 16;
    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_payload_byte = '0;
    logic        s_first_byte = 1'b0;
    logic        s_last_byte = 1'b0;
    logic [15:0] s_flow_tag = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_flow_out;
    logic [15:0] m_transaction_id;
    logic        m_is_response;
    logic [6:0]  m_function_code;
    logic        m_is_exception;
    logic [5:0]  m_present_mask;
    logic [7:0]  m_exception_code;
    logic [7:0]  m_byte_count_out;
    logic [16:0] m_address_out;
    logic [15:0] m_value_out;
    logic        m_last_result;

    modbus_tcp_transaction_parser DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] flow;
    } byte_item_t;

    // predictor state
    logic        pt_valid [NENT];
    logic [15:0] pt_flow [NENT];
    logic [15:0] pt_tid [NENT];
    logic [15:0] pt_start [NENT];
    logic [15:0] pos;
    logic [15:0] cur_flow, cur_tid;
    logic        hdr_ok;
    int          hit;
    logic [7:0]  raw_fc;
    logic [7:0]  pdu [5];
    logic [7:0]  reg_hi;

    result_t     expected_q [$];
    byte_item_t  byte_q [$];
    int          mismatches = 0;
    int          sent = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;

    function automatic result_t mk(kind_t k, logic r, logic [6:0] fc, logic ex,
                                   logic [5:0] m, logic [7:0] e, logic [7:0] bc,
                                   logic [16:0] a, logic [15:0] v, logic l);
        result_t x;
        x.kind = k; x.flow = cur_flow; x.tid = cur_tid; x.is_resp = r; x.fc = fc;
        x.is_exc = ex; x.mask = m; x.err = e; x.bc = bc; x.addr = a; x.val = v;
        x.last = l;
        return x;
    endfunction

    task automatic parse_byte(byte_item_t it);
        logic [15:0] p;
        int          idx, dl;
        logic        resp, exc, stored;
        logic [5:0]  m;
        logic [7:0]  e, bc;
        logic [16:0] a;
        logic [15:0] v, w0, w1, st;
        if (it.first) pos = 0;
        if (pos == 0) begin
            cur_flow = it.flow; cur_tid = 0; hdr_ok = 0; hit = 0; raw_fc = 0;
            foreach (pdu[i]) pdu[i] = 0;
            reg_hi = 0;
        end
        p = pos;
        if (p == 0) cur_tid = {it.data, 8'h00};
        else if (p == 1) begin
            cur_tid[7:0] = it.data;
            for (int i = 0; i < NENT; i++)
                if (hit == 0 && pt_valid[i] && pt_flow[i] == cur_flow && pt_tid[i] == cur_tid)
                    hit = i + 1;
        end else if (p == 2) hdr_ok = (it.data == 0);
        else if (p == 3) hdr_ok = hdr_ok && (it.data == 0);
        else if (p == 7) raw_fc = it.data;
        else if (p >= 8 && p <= 12) pdu[p-8] = it.data;
        if (p >= 9 && p < 16'hFFFF) begin
            if (((p - 9) & 1) == 0) reg_hi = it.data;
            else begin
                idx = (p - 10) >> 1;
                if (hit != 0 && hdr_ok && raw_fc >= 1 && raw_fc <= 4 && pdu[0] > 0
                    && idx < pdu[0] / 2)
                    expected_q.push_back(mk(KIND_REG, 1, raw_fc[6:0], 0, 0, 0, 0,
                        17'(pt_start[hit-1]) + 17'(idx), {reg_hi, it.data}, 0));
            end
        end
        if (it.last) begin
            if (int'(p) + 1 < 8 || !hdr_ok)
                expected_q.push_back(mk(KIND_IGNORED, 0, 0, 0, 0, 0, 0, 0, 0, 1));
            else begin
                dl = int'(p) + 1 - 8;
                resp = (hit != 0);
                exc = raw_fc > FC_EXC_BIT;
                m = 0; e = 0; bc = 0; a = 0; v = 0;
                w0 = {pdu[0], pdu[1]}; w1 = {pdu[2], pdu[3]};
                if (exc) begin
                    if (dl >= 1) begin m[0] = 1; e = pdu[0]; end
                end else if (raw_fc >= 1 && raw_fc <= 4) begin
                    if (resp) begin
                        if (dl >= 1) begin m[1] = 1; bc = pdu[0]; end
                    end else if (dl >= 4) begin m[2] = 1; m[3] = 1; a = w0; v = w1; end
                end else if (raw_fc == 5 || raw_fc == 6) begin
                    if (dl >= 4) begin m[2] = 1; m[4] = 1; a = w0; v = w1; end
                end else if (raw_fc == 15 || raw_fc == 16) begin
                    if (resp) begin
                        if (dl >= 4) begin m[2] = 1; m[3] = 1; a = w0; v = w1; end
                    end else if (dl >= 5) begin
                        m[1] = 1; m[2] = 1; m[3] = 1; a = w0; v = w1; bc = pdu[4];
                    end
                end
                if (resp) pt_valid[hit-1] = 0;
                else begin
                    stored = 0;
                    st = (((raw_fc >= 1 && raw_fc <= 6) || raw_fc == 15 || raw_fc == 16)
                          && dl >= 3) ? w0 : 16'h0;
                    for (int i = 0; i < NENT; i++)
                        if (!stored && !pt_valid[i]) begin
                            pt_valid[i] = 1; pt_flow[i] = cur_flow; pt_tid[i] = cur_tid;
                            pt_start[i] = st; stored = 1;
                        end
                    if (!stored) m[5] = 1;
                end
                expected_q.push_back(mk(KIND_SUMMARY, resp, raw_fc[6:0], exc, m, e, bc,
                    a, v, 1));
            end
            pos = 0;
        end else if (pos != 16'hFFFF) pos++;
    endtask

    // packet builders
    function automatic void add_packet(logic [15:0] flow, logic [7:0] bytes[$]);
        byte_item_t it;
        foreach (bytes[i]) begin
            it.data = bytes[i];
            it.first = (i == 0);
            it.last = (i == bytes.size() - 1);
            it.flow = (i == 0) ? flow : 16'($urandom);
            byte_q.push_back(it);
        end
    endfunction

    function automatic void add_modbus(logic [15:0] flow, logic [15:0] tid, logic [7:0] fc,
                                       logic [7:0] pdata[$], bit bad_proto);
        logic [7:0] b[$];
        b = {tid[15:8], tid[7:0], bad_proto ? 8'($urandom_range(1, 255)) : 8'h00, 8'h00,
             8'($urandom), 8'($urandom), 8'($urandom), fc};
        b = {b, pdata};
        add_packet(flow, b);
    endfunction

    // directed rows: flow, tid, function, data length, broken protocol id
    typedef struct {
        logic [15:0] flow;
        logic [15:0] tid;
        logic [7:0]  fc;
        int          dlen;
        bit          bad;
    } row_t;

    row_t rows[] = '{
        '{16'h0000, 16'h0000, 8'h03, 4, 0},
        '{16'h0000, 16'h0000, 8'h03, 7, 0},
        '{16'hFFFF, 16'hFFFF, 8'h10, 9, 0},
        '{16'hFFFF, 16'hFFFF, 8'h10, 4, 0},
        '{16'h1234, 16'h00FF, 8'h05, 4, 0},
        '{16'h1234, 16'hFF00, 8'h06, 2, 0},
        '{16'h0001, 16'h0001, 8'h83, 1, 0},
        '{16'h0001, 16'h0002, 8'h80, 3, 0},
        '{16'h0002, 16'h0003, 8'hFF, 0, 0},
        '{16'h0002, 16'h0004, 8'h41, 2, 0},
        '{16'h0003, 16'h0005, 8'h0F, 4, 1},
        '{16'h0004, 16'h0006, 8'h01, 4, 0},
        '{16'h0004, 16'h0006, 8'h01, 3, 0},
        '{16'h0005, 16'h0007, 8'h02, 3, 0},
        '{16'h0005, 16'h0007, 8'h04, 0, 0}
    };

    function automatic void add_row(row_t r);
        logic [7:0] d[$];
        for (int i = 0; i < r.dlen; i++) d.push_back(8'($urandom));
        // byte count set to the data actually sent: read rows of seven bytes and all rows of three
        if (r.fc inside {[1:4]} && r.dlen == 7 || r.dlen == 3) d[0] = 8'(r.dlen - 1);
        add_modbus(r.flow, r.tid, r.fc, d, r.bad);
    endfunction

    function automatic void add_random_packet();
        logic [7:0] d[$];
        logic [7:0] fcs[] = '{1, 2, 3, 4, 5, 6, 15, 16, 8'h81, 8'h83, 8'h90, 8'h80, 0, 7};
        logic [15:0] flow, tid;
        int n, sel;
        byte_item_t it;
        sel = $urandom_range(0, 99);
        flow = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        tid = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        if (sel < 80) begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : $urandom_range(3, 6);
            for (int i = 0; i < n; i++) d.push_back(8'($urandom));
            if ($urandom_range(0, 1) && n > 0) d[0] = 8'($urandom_range(0, 2 * n));
            add_modbus(flow, tid, fcs[$urandom_range(0, fcs.size() - 1)], d,
                       $urandom_range(0, 15) == 0);
        end else if (sel < 90) begin
            n = $urandom_range(1, 7);
            for (int i = 0; i < n; i++) d.push_back(8'($urandom));
            add_packet(flow, d);
        end else begin
            // noise: random framing
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                it.data = 8'($urandom); it.first = $urandom_range(0, 3) == 0;
                it.last = $urandom_range(0, 4) == 0; it.flow = 16'($urandom);
                byte_q.push_back(it);
            end
        end
    endfunction

    task automatic send_all();
        byte_item_t it;
        int burst;
        int gap;
        burst = 0;
        while (byte_q.size() > 0) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst = $urandom_range(1, 30);
            end
            it = byte_q.pop_front();
            s_valid <= 1'b1;
            s_payload_byte <= it.data;
            s_first_byte <= it.first;
            s_last_byte <= it.last;
            s_flow_tag <= it.flow;
            parse_byte(it);
            sent++;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            burst--;
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (expected_q.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        foreach (pt_valid[i]) pt_valid[i] = 0;
        pos = 0; cur_flow = 0; cur_tid = 0; hdr_ok = 0; hit = 0; raw_fc = 0; reg_hi = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) add_row(rows[i]);
        // tiny packet and a long run of eighteen requests to fill the table
        add_packet(16'h0009, '{8'h00});
        for (int i = 0; i < 18; i++) add_modbus(16'h0077, 16'(i), 8'h03, '{0, 0, 0, 2}, 0);
        send_all();
        drain();
        for (int i = 0; i < 18; i++) add_modbus(16'h0077, 16'(i), 8'h03, '{4, 1, 2, 3, 4}, 0);
        send_all();
        // long hold-off on the receiver while bytes keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 30; i++) add_random_packet();
                send_all();
            end
        join
        drain();
        while (sent + byte_q.size() < 1650 && cycles < CYCLE_LIMIT / 2) begin
            add_random_packet();
            if (byte_q.size() > 200) begin
                send_all();
            end
        end
        send_all();
        drain();
        stim_done = 1'b1;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_off && (($urandom_range(0, 7) != 0) || (cycles % 512 > 300));
    end

    always @(posedge aclk) begin
        result_t got, exp;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            got = '{kind_t'(m_kind), m_flow_out, m_transaction_id, m_is_response,
                    m_function_code, m_is_exception, m_present_mask, m_exception_code,
                    m_byte_count_out, m_address_out, m_value_out, m_last_result};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %p", got);
            end else begin
                exp = expected_q.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", exp, got);
                end
            end
        end
        if (stim_done) begin
            if (mismatches == 0 && expected_q.size() == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
            $finish;
        end else if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule

// File: sim.f
hdl/mtp_pkg.sv
hdl/mtp_front.sv
hdl/mtp_back.sv
hdl/modbus_tcp_transaction_parser.sv
verif/testbench.sv
